/* src/orot_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orot_pkg
// shared types and sine helpers for the oriented rectangle overlap test
// ----------------------------------------------------------------------------
package orot_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned SizeW  = 23;
  localparam int unsigned AngW   = 16;
  localparam int unsigned TrigW  = 16;   // signed q2.14
  localparam int unsigned Q14One = 16384;
  localparam int unsigned CtrW   = 40;   // 2*center*16384, signed
  localparam int unsigned OffW   = 41;   // rotated offset
  localparam int unsigned PtW    = 42;   // corner coordinate
  localparam int unsigned PrjW   = 59;   // projection, one term
  localparam int unsigned DotW   = 60;   // projection, sum

  localparam int unsigned NumCorner = 4;
  localparam int unsigned NumAxis   = 4;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic        [SizeW-1:0]  w;
    logic        [SizeW-1:0]  h;
    logic        [AngW-1:0]   ang;
  } rect_in_t;

  typedef struct packed {
    logic signed [CoordW+1:0] cx2;  // 2x+w
    logic signed [CoordW+1:0] cy2;
    logic        [SizeW-1:0]  w;
    logic        [SizeW-1:0]  h;
    logic signed [TrigW-1:0]  sn;
    logic signed [TrigW-1:0]  cs;
  } rect_trig_t;

  typedef struct packed {
    logic signed [NumCorner-1:0][PtW-1:0] px;
    logic signed [NumCorner-1:0][PtW-1:0] py;
    logic signed [TrigW-1:0]              sn;
    logic signed [TrigW-1:0]              cs;
  } rect_pts_t;

  // quarter-wave entry from its q30 angle, evaluated only at elaboration
  function automatic longint unsigned quarter_entry(input longint unsigned x);
    longint unsigned x2, t, s, q;
    x2 = (x * x) >> 30;
    t  = 64'd172272;
    t  = 64'd5026995    - ((x2 * t) >> 30);
    t  = 64'd85569306   - ((x2 * t) >> 30);
    t  = 64'd693598668  - ((x2 * t) >> 30);
    t  = 64'd1686629713 - ((x2 * t) >> 30);
    s  = (x * t) >> 30;
    q  = (s + 64'd32768) >> 16;
    if (q > Q14One) q = Q14One;
    return q;
  endfunction

endpackage

/* src/orot_trig.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orot_trig
// sine and cosine lookup for one rectangle, center doubling, one register
// ----------------------------------------------------------------------------
module orot_trig #(
  parameter int unsigned SineTableDepth = 1024
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  orot_pkg::rect_in_t rect_i,
  output orot_pkg::rect_trig_t trig_o
);
  import orot_pkg::*;

  localparam int unsigned IdxW = $clog2(SineTableDepth + 1);

  logic [14:0] tbl [SineTableDepth+1];
  for (genvar k = 0; k <= SineTableDepth; k++) begin : g_tbl
    localparam longint unsigned EntryX = (longint'(k) << 30) / SineTableDepth;
    assign tbl[k] = 15'(quarter_entry(EntryX));
  end

  logic [AngW-1:0] ang_c;
  logic [IdxW-1:0] is, ic, addr_s, addr_c;
  assign ang_c  = rect_i.ang + AngW'(Q14One);
  assign is     = IdxW'((32'(rect_i.ang[13:0]) * SineTableDepth) >> 14);
  assign ic     = IdxW'((32'(ang_c[13:0]) * SineTableDepth) >> 14);
  // odd quadrants read the table backwards
  assign addr_s = rect_i.ang[14] ? IdxW'(SineTableDepth) - is : is;
  assign addr_c = ang_c[14] ? IdxW'(SineTableDepth) - ic : ic;

  logic signed [CoordW+1:0] cx2_q, cy2_q;
  logic        [SizeW-1:0]  w_q, h_q;
  logic        [14:0]       sn_mag_q, cs_mag_q;
  logic                     sn_neg_q, cs_neg_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx2_q    <= {rect_i.x[CoordW-1], rect_i.x, 1'b0} + (CoordW+2)'(rect_i.w);
      cy2_q    <= {rect_i.y[CoordW-1], rect_i.y, 1'b0} + (CoordW+2)'(rect_i.h);
      w_q      <= rect_i.w;
      h_q      <= rect_i.h;
      sn_mag_q <= tbl[addr_s];
      cs_mag_q <= tbl[addr_c];
      sn_neg_q <= rect_i.ang[15];
      cs_neg_q <= ang_c[15];
    end
  end

  always_comb begin
    trig_o.cx2 = cx2_q;
    trig_o.cy2 = cy2_q;
    trig_o.w   = w_q;
    trig_o.h   = h_q;
    trig_o.sn  = sn_neg_q ? -$signed({1'b0, sn_mag_q}) : $signed({1'b0, sn_mag_q});
    trig_o.cs  = cs_neg_q ? -$signed({1'b0, cs_mag_q}) : $signed({1'b0, cs_mag_q});
  end
endmodule

/* src/orot_corner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orot_corner
// rotated corners: products registered, then summed with the center
// ----------------------------------------------------------------------------
module orot_corner (
  input  logic                 clk_i,
  input  logic                 en1_i,
  input  logic                 en2_i,
  input  orot_pkg::rect_trig_t trig_i,
  output orot_pkg::rect_pts_t  pts_o
);
  import orot_pkg::*;

  localparam int unsigned MW = SizeW + TrigW + 1;

  logic signed [MW-1:0] wc_q, ws_q, hc_q, hs_q;
  logic signed [CtrW-1:0] cx_q, cy_q;
  logic signed [TrigW-1:0] sn_q, cs_q;

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      wc_q <= $signed({1'b0, trig_i.w}) * trig_i.cs;
      ws_q <= $signed({1'b0, trig_i.w}) * trig_i.sn;
      hc_q <= $signed({1'b0, trig_i.h}) * trig_i.cs;
      hs_q <= $signed({1'b0, trig_i.h}) * trig_i.sn;
      cx_q <= {trig_i.cx2, 14'd0};
      cy_q <= {trig_i.cy2, 14'd0};
      sn_q <= trig_i.sn;
      cs_q <= trig_i.cs;
    end
  end

  // corner signs (dx,dy): (-w,+h) (+w,+h) (+w,-h) (-w,-h)
  rect_pts_t d;
  always_comb begin
    logic signed [PtW-1:0] wc, ws, hc, hs, cx, cy;
    wc = PtW'(wc_q); ws = PtW'(ws_q); hc = PtW'(hc_q); hs = PtW'(hs_q);
    cx = PtW'(cx_q); cy = PtW'(cy_q);
    d.px[0] = cx - wc - hs;  d.py[0] = cy - ws + hc;
    d.px[1] = cx + wc - hs;  d.py[1] = cy + ws + hc;
    d.px[2] = cx + wc + hs;  d.py[2] = cy + ws - hc;
    d.px[3] = cx - wc + hs;  d.py[3] = cy - ws - hc;
    d.sn = sn_q;
    d.cs = cs_q;
  end

  always_ff @(posedge clk_i) begin
    if (en2_i) pts_o <= d;
  end
endmodule

/* src/orot_sat.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orot_sat
// projection of eight corners on four axes, min/max and interval compare
// ----------------------------------------------------------------------------
module orot_sat (
  input  logic                clk_i,
  input  logic                en1_i,
  input  logic                en2_i,
  input  logic                en3_i,
  input  orot_pkg::rect_pts_t a_i,
  input  orot_pkg::rect_pts_t b_i,
  output logic                overlap_o
);
  import orot_pkg::*;

  logic signed [TrigW-1:0] ax [NumAxis], ay [NumAxis];
  always_comb begin
    ax[0] = a_i.cs;  ay[0] = a_i.sn;
    ax[1] = -a_i.sn; ay[1] = a_i.cs;
    ax[2] = b_i.cs;  ay[2] = b_i.sn;
    ax[3] = -b_i.sn; ay[3] = b_i.cs;
  end

  // products registered: [axis][rect][corner]
  logic signed [PrjW-1:0] mx_q [NumAxis][2][NumCorner];
  logic signed [PrjW-1:0] my_q [NumAxis][2][NumCorner];
  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      for (int k = 0; k < NumAxis; k++) begin
        for (int c = 0; c < NumCorner; c++) begin
          mx_q[k][0][c] <= $signed(a_i.px[c]) * ax[k];
          my_q[k][0][c] <= $signed(a_i.py[c]) * ay[k];
          mx_q[k][1][c] <= $signed(b_i.px[c]) * ax[k];
          my_q[k][1][c] <= $signed(b_i.py[c]) * ay[k];
        end
      end
    end
  end

  logic signed [DotW-1:0] p_q [NumAxis][2][NumCorner];
  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      for (int k = 0; k < NumAxis; k++)
        for (int r = 0; r < 2; r++)
          for (int c = 0; c < NumCorner; c++)
            p_q[k][r][c] <= DotW'(mx_q[k][r][c]) + DotW'(my_q[k][r][c]);
    end
  end

  logic sep;
  always_comb begin
    logic signed [DotW-1:0] mn [2], mxv [2];
    sep = 1'b0;
    for (int k = 0; k < NumAxis; k++) begin
      for (int r = 0; r < 2; r++) begin
        mn[r] = p_q[k][r][0]; mxv[r] = p_q[k][r][0];
        for (int c = 1; c < NumCorner; c++) begin
          if (p_q[k][r][c] < mn[r])  mn[r]  = p_q[k][r][c];
          if (p_q[k][r][c] > mxv[r]) mxv[r] = p_q[k][r][c];
        end
      end
      if (mxv[0] < mn[1] || mn[0] > mxv[1]) sep = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3_i) overlap_o <= ~sep;
  end
endmodule

/* src/oriented_rect_overlap_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oriented_rect_overlap_test
// separating axis test on two rotated rectangles, one pair per cycle
// ----------------------------------------------------------------------------
// channel | dir | fields
// s_axis  | in  | a_x a_y a_w a_h a_angle b_x b_y b_w b_h b_angle (tdata)
// m_axis  | out | overlapping (tdata[0])
//
// six register stages: sine lookup, size products, corners, axis products,
// projection sums, min/max compare; one word per cycle while m_axis is ready.
// a stall on m_axis holds every stage; a bubble ahead of it is filled.
// reset clears stage valid bits only.
module oriented_rect_overlap_test #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_x a_y a_w a_h a_angle b_x b_y b_w b_h b_angle, zero pad to 224 bits
  input  logic [223:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // overlapping, zero pad
  output logic [7:0]   m_axis_tdata
);
  import orot_pkg::*;

  localparam int unsigned NStg = 6;

  logic [NStg-1:0] vld_q;
  logic [NStg-1:0] en;

  // stage i loads when its slot is empty or moves on
  always_comb begin
    en[NStg-1] = ~vld_q[NStg-1] | m_axis_tready;
    for (int i = NStg - 2; i >= 0; i--) en[i] = ~vld_q[i] | en[i+1];
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= s_axis_tvalid;
      for (int i = 1; i < NStg; i++)
        if (en[i]) vld_q[i] <= vld_q[i-1];
    end
  end

  rect_in_t ra, rb;
  assign ra = {s_axis_tdata[23:0], s_axis_tdata[47:24], s_axis_tdata[70:48],
               s_axis_tdata[93:71], s_axis_tdata[109:94]};
  assign rb = {s_axis_tdata[133:110], s_axis_tdata[157:134], s_axis_tdata[180:158],
               s_axis_tdata[203:181], s_axis_tdata[219:204]};

  rect_trig_t ta, tb;
  rect_pts_t  pa, pb;
  logic       ovl;

  orot_trig #(.SineTableDepth(SINE_TABLE_DEPTH)) u_trig_a (
    .clk_i, .en_i(en[0]), .rect_i(ra), .trig_o(ta));
  orot_trig #(.SineTableDepth(SINE_TABLE_DEPTH)) u_trig_b (
    .clk_i, .en_i(en[0]), .rect_i(rb), .trig_o(tb));

  orot_corner u_corner_a (.clk_i, .en1_i(en[1]), .en2_i(en[2]), .trig_i(ta), .pts_o(pa));
  orot_corner u_corner_b (.clk_i, .en1_i(en[1]), .en2_i(en[2]), .trig_i(tb), .pts_o(pb));

  orot_sat u_sat (.clk_i, .en1_i(en[3]), .en2_i(en[4]), .en3_i(en[5]),
                  .a_i(pa), .b_i(pb), .overlap_o(ovl));

  assign m_axis_tvalid = vld_q[NStg-1];
  assign m_axis_tdata  = {7'd0, ovl};
endmodule

/* bench/orot_overlap_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orot_overlap_checker
// Watches both stream channels of the oriented rectangle overlap test.
// For each accepted rectangle pair it computes the expected overlap flag.
// It then compares every returned word with the oldest expected flag.
// ----------------------------------------------------------------------------
module orot_overlap_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [223:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [7:0]   m_axis_tdata,
  output int           err_count_o,
  output int           pending_o
);
  import orot_pkg::*;

  localparam int unsigned TableDepth = 1024;

  bit   overlap_fifo[$];
  logic [223:0] pair_word;

  // quarter-wave sine entry in q2.14
  function automatic longint quarter_sine(input longint unsigned k);
    longint unsigned x, x2, t, s, q;
    x  = (k << 30) / TableDepth;
    x2 = (x * x) >> 30;
    t  = 172272;
    t  = 5026995 - ((x2 * t) >> 30);
    t  = 85569306 - ((x2 * t) >> 30);
    t  = 693598668 - ((x2 * t) >> 30);
    t  = 1686629713 - ((x2 * t) >> 30);
    s  = (x * t) >> 30;
    q  = (s + 32768) >> 16;
    if (q > Q14One) q = Q14One;
    return longint'(q);
  endfunction

  function automatic longint sine_of(input logic [AngW-1:0] ang);
    logic [1:0]      quad;
    longint unsigned idx;
    longint          v;
    quad = ang[15:14];
    idx  = (longint'(ang[13:0]) * TableDepth) >> 14;
    v    = quad[0] ? quarter_sine(TableDepth - idx) : quarter_sine(idx);
    return quad[1] ? -v : v;
  endfunction

  // corners of one rectangle, doubled and scaled by 16384
  function automatic void rect_corners(input logic signed [CoordW-1:0] x,
                                       input logic signed [CoordW-1:0] y,
                                       input logic [SizeW-1:0] w,
                                       input logic [SizeW-1:0] h,
                                       input logic [AngW-1:0] ang,
                                       output longint px[4], output longint py[4],
                                       output longint sn, output longint cs);
    longint cx, cy, dx, dy;
    cx = (2 * longint'(x) + longint'(w)) * Q14One;
    cy = (2 * longint'(y) + longint'(h)) * Q14One;
    sn = sine_of(ang);
    cs = sine_of(ang + 16'd16384);
    for (int i = 0; i < 4; i++) begin
      dx = (i == 0 || i == 3) ? -longint'(w) : longint'(w);
      dy = (i < 2) ? longint'(h) : -longint'(h);
      px[i] = cx + dx * cs - dy * sn;
      py[i] = cy + dx * sn + dy * cs;
    end
  endfunction

  function automatic bit rects_overlap(input logic [223:0] d);
    longint apx[4], apy[4], bpx[4], bpy[4];
    longint asn, acs, bsn, bcs, ax[4], ay[4];
    longint mina, maxa, minb, maxb, p;
    rect_corners(d[23:0], d[47:24], d[70:48], d[93:71], d[109:94],
                 apx, apy, asn, acs);
    rect_corners(d[133:110], d[157:134], d[180:158], d[203:181], d[219:204],
                 bpx, bpy, bsn, bcs);
    ax = '{acs, -asn, bcs, -bsn};
    ay = '{asn, acs, bsn, bcs};
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 4; i++) begin
        p = apx[i] * ax[k] + apy[i] * ay[k];
        if (i == 0 || p < mina) mina = p;
        if (i == 0 || p > maxa) maxa = p;
        p = bpx[i] * ax[k] + bpy[i] * ay[k];
        if (i == 0 || p < minb) minb = p;
        if (i == 0 || p > maxb) maxb = p;
      end
      if (maxa < minb || mina > maxb) return 1'b0;
    end
    return 1'b1;
  endfunction

  assign pair_word = s_axis_tdata;

  initial begin
    err_count_o = 0;
    pending_o   = 0;
  end

  always @(posedge clk_i) begin
    bit want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) overlap_fifo.push_back(rects_overlap(pair_word));
      if (m_axis_tvalid && m_axis_tready) begin
        if (overlap_fifo.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, m_axis_tdata);
          err_count_o++;
        end else begin
          want = overlap_fifo.pop_front();
          if (m_axis_tdata !== {7'd0, want}) begin
            $display("%0t: overlapping mismatch, expected %0d, actual %h",
                     $time, want, m_axis_tdata);
            err_count_o++;
          end
        end
      end
      pending_o = overlap_fifo.size();
    end
  end

endmodule

/* bench/tb_oriented_rect_overlap_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_oriented_rect_overlap_test
// Stream testbench for the oriented rectangle overlap test.
// A directed set of rectangle pairs comes first, then random pairs, most of
// them placed near each other. Both sides idle at random, and the receiver
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_oriented_rect_overlap_test;
  import orot_pkg::*;

  localparam int NumRandom = 600;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [223:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;
  logic [223:0] pair_word = '0;
  int           err_count, pending, sent;
  bit           quiet, hold_req;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  oriented_rect_overlap_test DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  orot_overlap_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .err_count_o(err_count), .pending_o(pending)
  );

  task automatic send_pair(input logic [23:0] ax, input logic [23:0] ay,
                           input logic [22:0] aw, input logic [22:0] ah,
                           input logic [15:0] aang,
                           input logic [23:0] bx, input logic [23:0] by,
                           input logic [22:0] bw, input logic [22:0] bh,
                           input logic [15:0] bang);
    while (!quiet && $urandom_range(99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    pair_word = {4'd0, bang, bh, bw, by, bx, aang, ah, aw, ay, ax};
    s_axis_tdata  <= pair_word;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    @(negedge clk_i);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 38);
      end
    end
  end

  initial begin
    #(12 * 150000);
    $display("tb_oriented_rect_overlap_test: done, errors");
    $finish;
  end

  initial begin
    logic [23:0] bx0, by0;
    logic [22:0] span;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // extremes, zero sizes, cardinal angles, touching edges
    send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(24'h800000, 24'h800000, 23'h7fffff, 23'h7fffff, 16'hffff,
              24'h7fffff, 24'h7fffff, 23'h7fffff, 23'h7fffff, 16'hffff);
    send_pair(24'h7fffff, 24'h800000, 0, 0, 16'h4000,
              24'h800000, 24'h7fffff, 0, 0, 16'h8000);
    send_pair(0, 0, 256, 256, 0, 256, 0, 256, 256, 0);
    send_pair(0, 0, 256, 256, 0, 257, 0, 256, 256, 0);
    send_pair(0, 0, 256, 256, 0, 0, 256, 256, 256, 0);
    send_pair(0, 0, 256, 256, 16'h4000, 256, 0, 256, 256, 16'hc000);
    send_pair(0, 0, 512, 512, 16'h2000, 600, 600, 512, 512, 16'h2000);
    send_pair(0, 0, 512, 512, 16'h2000, 300, 300, 512, 512, 16'h6000);
    send_pair(0, 0, 1000, 0, 16'h1000, 500, -24'sd300, 0, 1000, 16'h1000);
    send_pair(100, 100, 0, 0, 0, 100, 100, 0, 0, 16'h8000);
    send_pair(100, 100, 0, 0, 0, 101, 100, 0, 0, 0);
    send_pair(-24'sd5000, -24'sd5000, 4000, 9000, 16'h8000,
              -24'sd2000, -24'sd2000, 3000, 100, 16'h0001);
    send_pair(0, 0, 23'h7fffff, 10, 16'h3fff, 24'h100000, 0, 10, 10, 16'h7fff);
    send_pair(24'h400000, 24'hc00000, 23'h400000, 23'h400000, 16'hbfff,
              24'hc00000, 24'h400000, 23'h400000, 23'h400000, 16'h4001);

    for (int n = 0; n < NumRandom; n++) begin
      quiet    = (n >= 250 && n < 350);
      if (n == 150) hold_req = 1'b1;
      if (n == 420) begin
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
      if ($urandom_range(4) == 0) begin
        send_pair(24'($urandom), 24'($urandom), 23'($urandom), 23'($urandom),
                  16'($urandom), 24'($urandom), 24'($urandom), 23'($urandom),
                  23'($urandom), 16'($urandom));
      end else begin
        span = 23'(1) << $urandom_range(16, 4);
        bx0 = 24'($urandom);
        by0 = 24'($urandom);
        send_pair(bx0, by0, 23'($urandom_range(span)), 23'($urandom_range(span)),
                  16'($urandom),
                  bx0 + 24'(int'($urandom_range(2 * span)) - int'(span)),
                  by0 + 24'(int'($urandom_range(2 * span)) - int'(span)),
                  23'($urandom_range(span)), 23'($urandom_range(span)),
                  16'($urandom));
      end
    end
    quiet = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (err_count == 0) begin
      $display("tb_oriented_rect_overlap_test: done, clean");
    end else begin
      $display("tb_oriented_rect_overlap_test: done, errors");
    end
    $finish;
  end

endmodule
